/* rtl/core/cpr_pkg.sv */
// Package for the CLOCK page replacement block: sizes, payload structs,
// memory word layouts and the controller state type.
// No dependencies; cpr_ctrl and the top level import it.
package cpr_pkg;

	// Slot count and derived widths.
	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

	// Fixed field widths of the beats.
	localparam int FILE_W   = 16;
	localparam int PAGE_W   = 32;
	localparam int IDX_W    = 6;
	localparam int POOL_W   = 7;
	localparam int TAG_W    = FILE_W + PAGE_W;
	localparam int FLAG_W   = 2;

	// Access kinds.
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic              func;
		logic [FILE_W-1:0] file_id;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  slot_index;
		logic              evicted;
		logic [FILE_W-1:0] victim_file;
		logic [PAGE_W-1:0] victim_page;
		logic              victim_dirty;
	} rsp_t;

	typedef struct packed {
		logic [FILE_W-1:0] file_id;
		logic [PAGE_W-1:0] page_number;
	} tag_t;

	typedef struct packed {
		logic referenced;
		logic dirty;
	} flag_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_SWRD,
		S_SWEEP,
		S_DONE
	} state_t;

endpackage

/* rtl/core/cpr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the tag store and the flag store.
module cpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/cpr_ctrl.sv */
// Lookup and replacement controller: scans the tag store, updates the flag
// store, sweeps the clock hand. Uses cpr_pkg and two cpr_ram instances.
module cpr_ctrl
	import cpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [POOL_W-1:0] pool_size,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              res_valid,
	input  logic              res_ready,
	output rsp_t              res
);

	state_t            state_q, state_d;
	req_t              req_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] hand_q;
	logic [CNT_W-1:0]  fill_q;
	rsp_t              res_q;

	logic [CNT_W-1:0]  n_eff;
	logic              match;
	logic              scan_last;
	logic              fill_room;
	logic [SLOT_W-1:0] hand_start;
	logic [SLOT_W-1:0] next_idx;

	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_addr;
	logic              tag_we;
	logic              flag_we;
	flag_t             flag_wdata;
	tag_t              new_tag;
	tag_t              rd_tag;
	flag_t             rd_flag;

	// Tag and flag stores; a slot is valid exactly when it lies below fill_q
	cpr_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (wr_addr),
		.wdata (new_tag),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_tag)
	);

	cpr_ram #(.WIDTH(FLAG_W), .DEPTH(NUM_SLOTS)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (wr_addr),
		.wdata (flag_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_flag)
	);

	// Saturate the pool size to 1..NUM_SLOTS
	always_comb begin
		if (pool_size == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(pool_size) > NUM_SLOTS) begin
			n_eff = CNT_W'(NUM_SLOTS);
		end else begin
			n_eff = CNT_W'(pool_size);
		end
	end

	// Compare, bounds and hand arithmetic
	assign new_tag    = '{file_id: req_q.file_id, page_number: req_q.page_number};
	assign match      = (rd_tag == new_tag);
	assign scan_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
	assign fill_room  = (fill_q < n_eff);
	assign hand_start = (CNT_W'(hand_q) < n_eff) ? hand_q : '0;
	assign next_idx   = ((CNT_W'(idx_q) + CNT_W'(1)) < n_eff) ? (idx_q + SLOT_W'(1)) : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (fill_q == '0) ? S_MISS : S_SCAN;
				end
			end
			S_SCAN: begin
				if (match) begin
					state_d = S_DONE;
				end else if (scan_last) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				state_d = fill_room ? S_DONE : S_SWRD;
			end
			S_SWRD: begin
				state_d = S_SWEEP;
			end
			S_SWEEP: begin
				state_d = rd_flag.referenced ? S_SWRD : S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memory controls and handshake outputs
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		wr_addr    = idx_q;
		tag_we     = 1'b0;
		flag_we    = 1'b0;
		flag_wdata = '{referenced: 1'b1, dirty: req_q.func};
		req_ready  = 1'b0;
		res_valid  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				rd_en     = req_valid;
				rd_addr   = '0;
			end
			S_SCAN: begin
				if (match) begin
					flag_we    = 1'b1;
					flag_wdata = '{referenced: 1'b1,
						dirty: rd_flag.dirty | (req_q.func == FUNC_WRITE)};
				end else if (!scan_last) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + SLOT_W'(1);
				end
			end
			S_MISS: begin
				if (fill_room) begin
					wr_addr = SLOT_W'(fill_q);
					tag_we  = 1'b1;
					flag_we = 1'b1;
				end
			end
			S_SWRD: begin
				rd_en = 1'b1;
			end
			S_SWEEP: begin
				flag_we = 1'b1;
				if (rd_flag.referenced) begin
					flag_wdata = '{referenced: 1'b0, dirty: rd_flag.dirty};
				end else begin
					tag_we = 1'b1;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign res = res_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			hand_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MISS && fill_room) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (state_q == S_SWEEP && !rd_flag.referenced) begin
				hand_q <= next_idx;
			end
		end
	end

	// Request, position and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
					idx_q <= '0;
				end
			end
			S_SCAN: begin
				if (match) begin
					res_q <= '{hit: 1'b1, slot_index: IDX_W'(idx_q), evicted: 1'b0,
						victim_file: '0, victim_page: '0, victim_dirty: 1'b0};
				end else if (!scan_last) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end
			S_MISS: begin
				if (fill_room) begin
					res_q <= '{hit: 1'b0, slot_index: IDX_W'(fill_q), evicted: 1'b0,
						victim_file: '0, victim_page: '0, victim_dirty: 1'b0};
				end else begin
					idx_q <= hand_start;
				end
			end
			S_SWEEP: begin
				if (rd_flag.referenced) begin
					idx_q <= next_idx;
				end else begin
					res_q <= '{hit: 1'b0, slot_index: IDX_W'(idx_q), evicted: 1'b1,
						victim_file: rd_tag.file_id, victim_page: rd_tag.page_number,
						victim_dirty: rd_flag.dirty};
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// Fill count never passes the slot count
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(NUM_SLOTS))
		else $error("fill count beyond slot count");

	// Scan reads only filled slots
	a_scan_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CNT_W'(idx_q) < fill_q))
		else $error("scan beyond filled slots");

	// Sweep stays inside the pool and only runs on a full pool
	a_sweep_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> ((CNT_W'(idx_q) < n_eff) && !fill_room))
		else $error("sweep outside pool");

	// A hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.hit && res.evicted))
		else $error("hit with eviction");

	// Fill count moves only on a fill miss
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(state_q) == S_MISS))
		else $error("fill count moved outside a miss");

endmodule

/* rtl/core/clock_page_replacement.sv */
// Top level of the CLOCK page replacement block: pool size register,
// output register and the controller. Uses cpr_pkg and cpr_ctrl.
//
// One request beat (func, file_id, page_number) yields one response beat.
// The tag and flag stores are synchronous RAMs with one write and one read
// port; lookup reads one slot per cycle from slot 0 up to the lowest match or
// to the fill count. A hit or a miss with room then writes the response
// register. A miss on a full pool sweeps the clock hand, each slot it visits
// taking one read and then one check and write back, and the hand visits at
// most n_eff + 1 slots, n_eff being pool_size saturated to 1..NUM_SLOTS. The
// block takes a new request once the previous result sits in the output
// register. There is no clearing pass after reset: slot validity follows from
// the fill count.
module clock_page_replacement
	import cpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [POOL_W-1:0] cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	logic [POOL_W-1:0] pool_size_q;
	logic              out_valid_q;
	rsp_t              out_q;
	logic              res_valid;
	logic              res_ready;
	rsp_t              res;

	// Hold the pool size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_W'(NUM_SLOTS);
		end else if (cfg_we) begin
			pool_size_q <= cfg_wdata;
		end
	end

	cpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pool_size (pool_size_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: take a result when empty or draining
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
